FILE: hw/rtl/ptts_pkg.sv
// Package for the periodic task timer scheduler: word types, command and
// result codes, slot states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptts_pkg;
   localparam int SLOTS      = 16;
   localparam int SLOT_W     = 4;
   localparam int FIRE_LIMIT = 16;
   localparam int QDEPTH     = 2;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;
   localparam logic [1:0] CMD_SHUT   = 2'd3;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRE   = 2'd2;
   localparam logic [1:0] KIND_SHUT   = 2'd3;

   localparam logic [1:0] ST_FRESH  = 2'd0;
   localparam logic [1:0] ST_SCHED  = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;
   localparam logic [1:0] ST_CANCEL = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  slot;
      logic [31:0] time_value;
      logic        start_absolute;
      logic [30:0] period_ms;
      logic        resched_from_fire;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] task_slot;
      logic       ok;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: hw/rtl/ptts_front.sv
// Front end: accepts request words and queues them for the engine.
// Depends on ptts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptts_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  ptts_pkg::req_type     req_word,
   output logic                  q_valid,
   input  wire                   q_pop,
   output ptts_pkg::req_type     q_word
);
   ptts_pkg::req_type mem_ff [ptts_pkg::QDEPTH];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_ready = (cnt_ff != 2'(ptts_pkg::QDEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_word    = mem_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff ^ (q_pop && q_valid);
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_word;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/ptts_engine.sv
// Back end: slot table, clock and the tick scan sequencer; drives the
// result register. Depends on ptts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptts_engine (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_valid,
   output logic                  q_pop,
   input  ptts_pkg::req_type     q_word,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ptts_pkg::rsp_type     rsp_word
);
   typedef enum logic [1:0] {IDLE, SCAN, EMIT, HOLD} state_type;

   state_type   state_ff;
   logic [31:0] clock_ms_ff;
   logic        accepting_ff;
   logic [1:0]  status_ff [ptts_pkg::SLOTS];
   logic [31:0] due_ff    [ptts_pkg::SLOTS];
   logic [30:0] period_ff [ptts_pkg::SLOTS];
   logic        mode_ff   [ptts_pkg::SLOTS];
   logic [ptts_pkg::SLOTS-1:0] fired_ff;
   logic [3:0]  idx_ff;           // scan position
   logic        found_ff;
   logic [3:0]  best_ff;
   logic [31:0] best_due_ff;
   logic [4:0]  nfired_ff;
   logic        pend_ff;          // a fire word waits for its last flag
   logic [3:0]  pend_slot_ff;
   logic        rsp_valid_ff;
   ptts_pkg::rsp_type rsp_ff;

   logic       cand, better, more, add_ok, out_free;
   logic [31:0] base;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign q_pop     = (state_ff == IDLE) && q_valid && !rsp_valid_ff;

   always_comb begin
      cand     = (status_ff[idx_ff] == ptts_pkg::ST_SCHED) && !fired_ff[idx_ff] &&
                 (due_ff[idx_ff] < clock_ms_ff);
      better   = !found_ff || (due_ff[idx_ff] < best_due_ff);
      base     = mode_ff[best_ff] ? clock_ms_ff : due_ff[best_ff];
      more     = (nfired_ff != 5'(ptts_pkg::FIRE_LIMIT - 1));
      add_ok   = accepting_ff && (status_ff[q_word.slot] == ptts_pkg::ST_FRESH);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         clock_ms_ff  <= 32'd0;
         accepting_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ptts_pkg::SLOTS; i++) status_ff[i] <= ptts_pkg::ST_FRESH;
      end else begin
         case (state_ff)
            IDLE: begin
               if (q_pop) begin
                  case (q_word.cmd)
                     ptts_pkg::CMD_TICK: begin
                        clock_ms_ff <= clock_ms_ff + 32'd1;
                        fired_ff    <= '0;
                        idx_ff      <= 4'd0;
                        found_ff    <= 1'b0;
                        nfired_ff   <= 5'd0;
                        pend_ff     <= 1'b0;
                        state_ff    <= SCAN;
                     end
                     ptts_pkg::CMD_ADD: begin
                        rsp_ff       <= {ptts_pkg::KIND_ADD, q_word.slot, add_ok, 1'b1};
                        rsp_valid_ff <= 1'b1;
                        if (add_ok) begin
                           due_ff[q_word.slot] <= q_word.start_absolute ? q_word.time_value
                                                  : clock_ms_ff + q_word.time_value;
                           period_ff[q_word.slot] <= q_word.period_ms;
                           mode_ff[q_word.slot]   <= q_word.resched_from_fire;
                           status_ff[q_word.slot] <= ptts_pkg::ST_SCHED;
                        end
                     end
                     ptts_pkg::CMD_CANCEL: begin
                        rsp_ff <= {ptts_pkg::KIND_CANCEL, q_word.slot,
                                   (status_ff[q_word.slot] == ptts_pkg::ST_SCHED), 1'b1};
                        rsp_valid_ff <= 1'b1;
                        status_ff[q_word.slot] <= ptts_pkg::ST_CANCEL;
                     end
                     default: begin
                        rsp_ff       <= {ptts_pkg::KIND_SHUT, 4'd0, 1'b0, 1'b1};
                        rsp_valid_ff <= 1'b1;
                        accepting_ff <= 1'b0;
                        for (int i = 0; i < ptts_pkg::SLOTS; i++)
                           status_ff[i] <= ptts_pkg::ST_CANCEL;
                     end
                  endcase
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            SCAN: begin
               if (rsp_ready) rsp_valid_ff <= 1'b0;
               if (cand && better) begin
                  found_ff    <= 1'b1;
                  best_ff     <= idx_ff;
                  best_due_ff <= due_ff[idx_ff];
               end
               idx_ff <= idx_ff + 4'd1;
               if (idx_ff == 4'(ptts_pkg::SLOTS - 1)) state_ff <= EMIT;
            end
            EMIT: begin
               // The previous fire goes out now: last when this pass found nothing.
               if (out_free) begin
                  rsp_valid_ff <= pend_ff;
                  if (pend_ff)
                     rsp_ff <= {ptts_pkg::KIND_FIRE, pend_slot_ff, 1'b1, !found_ff};
                  pend_ff <= found_ff;
                  if (found_ff) begin
                     fired_ff[best_ff] <= 1'b1;
                     if (period_ff[best_ff] == 31'd0)
                        status_ff[best_ff] <= ptts_pkg::ST_DONE;
                     else
                        due_ff[best_ff] <= base + {1'b0, period_ff[best_ff]};
                     pend_slot_ff <= best_ff;
                     nfired_ff    <= nfired_ff + 5'd1;
                     idx_ff       <= 4'd0;
                     found_ff     <= 1'b0;
                     state_ff     <= more ? SCAN : HOLD;
                  end else begin
                     state_ff <= IDLE;
                  end
               end
            end
            default: begin
               // Fire limit hit: the held fire is the final word of the tick.
               if (out_free) begin
                  rsp_ff       <= {ptts_pkg::KIND_FIRE, pend_slot_ff, 1'b1, 1'b1};
                  rsp_valid_ff <= 1'b1;
                  pend_ff      <= 1'b0;
                  state_ff     <= IDLE;
               end
            end
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/periodic_task_timer_scheduler_top.sv
// Top level of the periodic task timer scheduler.
// Depends on ptts_pkg, ptts_front and ptts_engine.
//
// Request words (req_*) carry tick, add, cancel or shutdown commands.
// Result words (rsp_*) carry replies and fire events; last marks the final
// word that a request causes. A tick with nothing due gives no word.
// A two-word queue sits between the request port and the engine, so
// requests are taken while the engine scans or waits on the receiver.
// Add, cancel and shutdown: the request passes the queue, then the reply
// is registered; no new command is popped while a reply is still held.
// A tick: it is popped, then one scan pass over all SLOTS per fired task
// plus one closing empty pass. With 16 fires the closing pass is skipped
// and the held fire goes out as the final word of the tick.
// Each fire word is held until the following pass ends, so its last flag
// is known when it is presented.
// Reset clears the clock to zero, reopens adds and marks all slots fresh.
// A stalled receiver stalls the engine at the end of a pass or before the
// next command; the queue then fills and req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_timer_scheduler_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  ptts_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output ptts_pkg::rsp_type  rsp_data
);
   ptts_pkg::req_type q_word;
   logic q_valid, q_pop;

   ptts_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_data),
      .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
   );

   // The engine owns the result register directly.
   ptts_engine u_engine (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_data)
   );
endmodule
`default_nettype wire
